### sv/udc_pkg.sv
// Shared types and constants for the digit string converter.
package udc_pkg;

	localparam int VALUE_W    = 64;
	localparam int DIGIT_W    = 4;
	localparam int MAX_DIGITS = 64;
	localparam int DADDR_W    = $clog2(MAX_DIGITS);
	localparam int NDIG_W     = $clog2(MAX_DIGITS + 1);
	localparam int BYTES      = VALUE_W / 8;
	localparam int BIDX_W     = $clog2(BYTES);

	localparam int RADIX_W  = 4;
	localparam int MIN_W    = 6;
	localparam int BUDGET_W = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	localparam logic [RADIX_W-1:0]  RADIX_MIN    = 4'd2;
	localparam logic [RADIX_W-1:0]  RADIX_MAX    = 4'd10;
	localparam logic [RADIX_W-1:0]  RADIX_RESET  = 4'd10;
	localparam logic [MIN_W-1:0]    MIN_RESET    = 6'd0;
	localparam logic [BUDGET_W-1:0] BUDGET_RESET = 7'd64;

	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [7:0] ASCII_NINE = 8'h39;
	localparam logic [7:0] ASCII_NUL  = 8'h00;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RADIX       = 2'd0,
		REG_MIN_DIGITS  = 2'd1,
		REG_CHAR_BUDGET = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic               en;
		logic [DADDR_W-1:0] addr;
		logic [DIGIT_W-1:0] data;
	} ram_wr_t;

endpackage

### sv/udc_div_step.sv
// One byte of long division by the radix, eight restoring steps.
module udc_div_step import udc_pkg::*; (
	input  logic [RADIX_W-1:0] radix,
	input  logic [DIGIT_W-1:0] rem_in,
	input  logic [7:0]         byte_in,
	output logic [7:0]         quo,
	output logic [DIGIT_W-1:0] rem_out
);

	always_comb begin
		logic [DIGIT_W-1:0] r;
		logic [DIGIT_W:0]   acc;
		logic [DIGIT_W:0]   dif;
		r   = rem_in;
		quo = '0;
		for (int i = 7; i >= 0; i--) begin
			acc = {r, byte_in[i]};
			dif = acc - {1'b0, radix};
			if (acc >= {1'b0, radix}) begin
				quo[i] = 1'b1;
				r      = dif[DIGIT_W-1:0];
			end else begin
				r = acc[DIGIT_W-1:0];
			end
		end
		rem_out = r;
	end

endmodule

### sv/udc_digit_ram.sv
// Digit store: one write port, one registered read port.
module udc_digit_ram import udc_pkg::*; (
	input  logic               clk,
	input  ram_wr_t            wr,
	input  logic [DADDR_W-1:0] rd_addr,
	output logic [DIGIT_W-1:0] rd_data
);

	logic [DIGIT_W-1:0] mem [MAX_DIGITS];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

### sv/unsigned_to_digit_string.sv
// Top level: unsigned value to zero-padded ASCII digit string in radix 2 to 10.
//
// Usage:
//   src channel (src_valid/src_ready/value) takes one 64-bit value per beat.
//   dst channel (dst_valid/dst_ready) returns one character per beat:
//   pad '0' characters, the digits most significant first, then a NUL beat
//   with is_last set. A string that does not fit char_budget (capped at
//   MAX_CHARS) gives one beat with char_code 0, is_last and failed set.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes radix (0),
//   min_digits (1) and char_budget (2); radix is held to 2..10. Write it
//   only while the block is idle.
// Timing:
//   Each digit takes one pass of the shared byte divider over the significant
//   bytes of the running quotient, most significant byte first. A CHECK state
//   follows, then one character per cycle while dst_ready stays high.
//   src_ready is high only between values; a stalled receiver holds the
//   output register and the sequencer waits on it.
// Reset: registers return to radix 10, min_digits 0, char_budget 64.
module unsigned_to_digit_string import udc_pkg::*; #(
	parameter int MAX_CHARS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  src_valid,
	output logic                  src_ready,
	input  logic [VALUE_W-1:0]    value,
	output logic                  dst_valid,
	input  logic                  dst_ready,
	output logic [7:0]            char_code,
	output logic                  is_last,
	output logic                  failed,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int BUD_W = $clog2(MAX_CHARS + 1);
	localparam int CMP_W = ((BUD_W > BUDGET_W) ? BUD_W : BUDGET_W) + 1;

	typedef enum logic [2:0] {
		IDLE,
		DIVIDE,
		CHECK,
		PAD,
		DIGIT,
		TERM,
		FAIL
	} state_t;

	state_t              state_q;
	logic [RADIX_W-1:0]  radix_q;
	logic [MIN_W-1:0]    min_digits_q;
	logic [BUDGET_W-1:0] char_budget_q;
	logic [VALUE_W-1:0]  q_q;
	logic [DIGIT_W-1:0]  rem_q;
	logic [BIDX_W-1:0]   idx_q;
	logic [BIDX_W-1:0]   top_q;
	logic [NDIG_W-1:0]   ndig_q;
	logic [MIN_W-1:0]    pad_q;
	logic [DADDR_W-1:0]  ptr_q;
	logic                dst_valid_q;
	logic [7:0]          char_code_q;
	logic                is_last_q;
	logic                failed_q;

	logic [7:0]          quo;
	logic [DIGIT_W-1:0]  rem_n;
	logic [VALUE_W-1:0]  q_next;
	logic [BIDX_W-1:0]   top_n;
	logic [BIDX_W-1:0]   src_top;
	logic                div_done;
	logic [DADDR_W-1:0]  ptr_d;
	logic [DADDR_W-1:0]  ndig_m1;
	logic [DIGIT_W-1:0]  rd_data;
	ram_wr_t             ram_wr;
	logic                out_load;
	logic                out_fire;
	logic [NDIG_W-1:0]   len;
	logic [CMP_W-1:0]    budget;
	logic                str_fail;
	logic [RADIX_W-1:0]  radix_wr;

	udc_div_step u_div (
		.radix   (radix_q),
		.rem_in  (rem_q),
		.byte_in (q_q[{idx_q, 3'b000} +: 8]),
		.quo     (quo),
		.rem_out (rem_n)
	);

	udc_digit_ram u_ram (
		.clk     (clk),
		.wr      (ram_wr),
		.rd_addr (ptr_d),
		.rd_data (rd_data)
	);

	assign src_ready = (state_q == IDLE);
	assign cfg_ready = 1'b1;
	assign dst_valid = dst_valid_q;
	assign char_code = char_code_q;
	assign is_last   = is_last_q;
	assign failed    = failed_q;
	assign out_load  = !dst_valid_q || dst_ready;
	assign out_fire  = out_load && (state_q inside {PAD, DIGIT, TERM, FAIL});
	assign ndig_m1   = DADDR_W'(ndig_q - NDIG_W'(1));

	always_comb begin
		src_top = '0;
		for (int b = 0; b < BYTES; b++) begin
			if (value[b*8 +: 8] != 8'd0) begin
				src_top = BIDX_W'(b);
			end
		end
	end

	always_comb begin
		q_next = q_q;
		q_next[{idx_q, 3'b000} +: 8] = quo;
		top_n = top_q;
		if (top_q != '0 && q_next[{top_q, 3'b000} +: 8] == 8'd0) begin
			top_n = top_q - BIDX_W'(1);
		end
		div_done = (q_next == '0) || (ndig_q == NDIG_W'(MAX_DIGITS - 1));
	end

	always_comb begin
		ram_wr.en   = (state_q == DIVIDE) && (idx_q == '0);
		ram_wr.addr = ndig_q[DADDR_W-1:0];
		ram_wr.data = rem_n;
	end

	always_comb begin
		ptr_d = ptr_q;
		if (state_q == CHECK) begin
			ptr_d = ndig_m1;
		end else if (state_q == DIGIT && out_load && ptr_q != '0) begin
			ptr_d = ptr_q - DADDR_W'(1);
		end
	end

	always_comb begin
		len = (NDIG_W'(min_digits_q) > ndig_q) ? NDIG_W'(min_digits_q) : ndig_q;
		budget = (CMP_W'(char_budget_q) < CMP_W'(MAX_CHARS)) ?
			CMP_W'(char_budget_q) : CMP_W'(MAX_CHARS);
		str_fail = (CMP_W'(min_digits_q) >= budget) ||
			((CMP_W'(len) + CMP_W'(1)) > budget);
	end

	always_comb begin
		radix_wr = cfg_data[RADIX_W-1:0];
		if (radix_wr < RADIX_MIN) begin
			radix_wr = RADIX_MIN;
		end else if (radix_wr > RADIX_MAX) begin
			radix_wr = RADIX_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= IDLE;
			radix_q       <= RADIX_RESET;
			min_digits_q  <= MIN_RESET;
			char_budget_q <= BUDGET_RESET;
			q_q           <= '0;
			rem_q         <= '0;
			idx_q         <= '0;
			top_q         <= '0;
			ndig_q        <= '0;
			pad_q         <= '0;
			ptr_q         <= '0;
			dst_valid_q   <= 1'b0;
			char_code_q   <= ASCII_NUL;
			is_last_q     <= 1'b0;
			failed_q      <= 1'b0;
		end else begin
			ptr_q <= ptr_d;
			if (out_fire) begin
				dst_valid_q <= 1'b1;
			end else if (dst_ready) begin
				dst_valid_q <= 1'b0;
			end
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_RADIX:       radix_q       <= radix_wr;
					REG_MIN_DIGITS:  min_digits_q  <= cfg_data[MIN_W-1:0];
					REG_CHAR_BUDGET: char_budget_q <= cfg_data[BUDGET_W-1:0];
					default: ;
				endcase
			end
			unique case (state_q)
				IDLE: begin
					if (src_valid) begin
						q_q     <= value;
						rem_q   <= '0;
						top_q   <= src_top;
						idx_q   <= src_top;
						ndig_q  <= '0;
						state_q <= DIVIDE;
					end
				end
				DIVIDE: begin
					q_q <= q_next;
					if (idx_q != '0) begin
						rem_q <= rem_n;
						idx_q <= idx_q - BIDX_W'(1);
					end else begin
						rem_q  <= '0;
						ndig_q <= ndig_q + NDIG_W'(1);
						top_q  <= top_n;
						idx_q  <= top_n;
						if (div_done) begin
							state_q <= CHECK;
						end
					end
				end
				CHECK: begin
					if (str_fail) begin
						state_q <= FAIL;
					end else if (NDIG_W'(min_digits_q) > ndig_q) begin
						pad_q   <= MIN_W'(NDIG_W'(min_digits_q) - ndig_q);
						state_q <= PAD;
					end else begin
						state_q <= DIGIT;
					end
				end
				PAD: begin
					if (out_load) begin
						char_code_q <= ASCII_ZERO;
						is_last_q   <= 1'b0;
						failed_q    <= 1'b0;
						pad_q       <= pad_q - MIN_W'(1);
						if (pad_q == MIN_W'(1)) begin
							state_q <= DIGIT;
						end
					end
				end
				DIGIT: begin
					if (out_load) begin
						char_code_q <= ASCII_ZERO + {4'd0, rd_data};
						is_last_q   <= 1'b0;
						failed_q    <= 1'b0;
						if (ptr_q == '0) begin
							state_q <= TERM;
						end
					end
				end
				TERM: begin
					if (out_load) begin
						char_code_q <= ASCII_NUL;
						is_last_q   <= 1'b1;
						failed_q    <= 1'b0;
						state_q     <= IDLE;
					end
				end
				FAIL: begin
					if (out_load) begin
						char_code_q <= ASCII_NUL;
						is_last_q   <= 1'b1;
						failed_q    <= 1'b1;
						state_q     <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

### sv/udc_checker.sv
// Port-level checks for the digit string converter and their bind.
module udc_checker import udc_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       src_valid,
	input logic       src_ready,
	input logic       dst_valid,
	input logic       dst_ready,
	input logic [7:0] char_code,
	input logic       is_last,
	input logic       failed
);

	a_dst_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && !dst_ready |=> dst_valid && $stable(char_code) &&
		$stable(is_last) && $stable(failed))
		else $error("dst beat changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		src_valid && src_ready |=> !src_ready)
		else $error("src ready right after an accepted beat");

	a_fail_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && failed |-> is_last)
		else $error("failed beat without is_last");

	a_last_is_nul: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && is_last |-> char_code == ASCII_NUL)
		else $error("last beat carries a character");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && !is_last |-> char_code >= ASCII_ZERO && char_code <= ASCII_NINE)
		else $error("character beat outside the digit range");

endmodule

bind unsigned_to_digit_string udc_checker u_udc_checker (.*);

### bench/tb_unsigned_to_digit_string.sv
// Testbench for unsigned_to_digit_string: random flow control, scoreboard checks every character beat.
module tb_unsigned_to_digit_string;
	import udc_pkg::*;

	localparam int CHAR_CAP       = 64;
	localparam int QUIET_LIMIT    = 4000;
	localparam int SQUEEZE_CYCLES = 400;
	localparam int SETTLE_CYCLES  = 8;
	localparam int PHASES         = 10;
	localparam int PHASE_ITEMS    = 26;
	localparam int MAX_REPORTS    = 200;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam logic [VALUE_W-1:0]   ALL_ONES   = '1;
	localparam logic [VALUE_W-1:0]   TOP_BIT    = 64'h8000_0000_0000_0000;

	typedef struct packed {
		logic [7:0] code;
		logic       last;
		logic       fail;
	} char_beat_t;

	class digit_scoreboard;
		char_beat_t          expected_q[$];
		int                  errors;
		logic [RADIX_W-1:0]  radix_r;
		logic [MIN_W-1:0]    min_digits_r;
		logic [BUDGET_W-1:0] budget_r;

		function new();
			errors       = 0;
			radix_r      = RADIX_RESET;
			min_digits_r = MIN_RESET;
			budget_r     = BUDGET_RESET;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			logic [RADIX_W-1:0] r;
			r = data[RADIX_W-1:0];
			case (idx)
				REG_RADIX: begin
					if (r < RADIX_MIN)
						r = RADIX_MIN;
					if (r > RADIX_MAX)
						r = RADIX_MAX;
					radix_r = r;
				end
				REG_MIN_DIGITS: min_digits_r = data[MIN_W-1:0];
				REG_CHAR_BUDGET: budget_r = data[BUDGET_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_value(logic [VALUE_W-1:0] v);
			logic [VALUE_W-1:0] q;
			logic [DIGIT_W-1:0] digs [MAX_DIGITS];
			int                 ndig;
			int                 len;
			int                 budget;
			int                 mind;
			int                 i;
			q      = v;
			ndig   = 0;
			mind   = int'(min_digits_r);
			budget = (int'(budget_r) > CHAR_CAP) ? CHAR_CAP : int'(budget_r);
			do begin
				digs[ndig] = DIGIT_W'(q % radix_r);
				q = q / radix_r;
				ndig++;
			end while (q != 0 && ndig < MAX_DIGITS);
			len = (mind > ndig) ? mind : ndig;
			if (mind >= budget || len + 1 > budget) begin
				expected_q.push_back(char_beat_t'({ASCII_NUL, 1'b1, 1'b1}));
				return;
			end
			for (i = 0; i < len - ndig; i++)
				expected_q.push_back(char_beat_t'({ASCII_ZERO, 1'b0, 1'b0}));
			for (i = ndig - 1; i >= 0; i--)
				expected_q.push_back(char_beat_t'({8'(ASCII_ZERO + 8'(digs[i])), 1'b0, 1'b0}));
			expected_q.push_back(char_beat_t'({ASCII_NUL, 1'b1, 1'b0}));
		endfunction

		task report(string msg);
			errors++;
			if (errors <= MAX_REPORTS)
				$display("mismatch: %s", msg);
		endtask

		task check_char(logic [7:0] code, logic last, logic fail);
			char_beat_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected beat char_code %h is_last %b failed %b",
					code, last, fail));
				return;
			end
			want = expected_q.pop_front();
			if (code !== want.code)
				report($sformatf("char_code %h, expected %h", code, want.code));
			if (last !== want.last)
				report($sformatf("is_last %b, expected %b", last, want.last));
			if (fail !== want.fail)
				report($sformatf("failed %b, expected %b", fail, want.fail));
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  src_valid;
	logic                  src_ready;
	logic [VALUE_W-1:0]    value;
	logic                  dst_valid;
	logic                  dst_ready;
	logic [7:0]            char_code;
	logic                  is_last;
	logic                  failed;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	logic src_beat;
	logic dst_beat;
	logic cfg_beat;

	digit_scoreboard    sb;
	logic [VALUE_W-1:0] directed_q[$];
	int                 rx_mode;
	int                 sender_idles;
	bit                 squeeze;
	int                 quiet_cycles = 0;

	assign src_beat = src_valid && (src_ready === 1'b1);
	assign dst_beat = (dst_valid === 1'b1) && dst_ready;
	assign cfg_beat = cfg_valid && (cfg_ready === 1'b1);

	unsigned_to_digit_string #(
		.MAX_CHARS(CHAR_CAP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.src_ready(src_ready),
		.value(value),
		.dst_valid(dst_valid),
		.dst_ready(dst_ready),
		.char_code(char_code),
		.is_last(is_last),
		.failed(failed),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (src_beat)
				sb.note_value(value);
			if (dst_beat)
				sb.check_char(char_code, is_last, failed);
			if (cfg_beat)
				sb.write_reg(cfg_index, cfg_data);
			if (src_beat || dst_beat || cfg_beat)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		int hold;
		int tick;
		hold = 0;
		tick = 0;
		dst_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (squeeze) begin
				squeeze = 1'b0;
				hold = SQUEEZE_CYCLES;
			end
			tick++;
			if (hold > 0) begin
				hold--;
				dst_ready <= 1'b0;
			end else begin
				case (rx_mode)
					0: dst_ready <= 1'b1;
					1: dst_ready <= 1'($urandom_range(0, 1));
					2: dst_ready <= (tick % 7) < 4;
					3: dst_ready <= ($urandom_range(0, 9) != 0);
					default: begin
						if ($urandom_range(0, 15) == 0) begin
							hold = $urandom_range(5, 40);
							dst_ready <= 1'b0;
						end else begin
							dst_ready <= 1'b1;
						end
					end
				endcase
			end
		end
	end

	function automatic logic [VALUE_W-1:0] pick_value();
		logic [VALUE_W-1:0] v;
		v = {$urandom, $urandom};
		if (directed_q.size() != 0)
			return directed_q.pop_front();
		case ($urandom_range(0, 5))
			0: ;
			1: v = VALUE_W'($urandom_range(0, 99));
			2: v = v >> $urandom_range(0, 63);
			3: v = ($urandom_range(0, 1) != 0) ? ALL_ONES : VALUE_W'($urandom_range(0, 1));
			default: v = v >> $urandom_range(32, 63);
		endcase
		return v;
	endfunction

	task set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_beat);
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	task send_value(input logic [VALUE_W-1:0] v);
		@(negedge clk);
		src_valid <= 1'b1;
		value     <= v;
		do @(posedge clk); while (!src_beat);
	endtask

	// offer values in bursts, then drain every expected beat
	task send_values(input int count);
		int sent;
		int burst;
		int gap;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 8);
			while (burst > 0 && sent < count) begin
				send_value(pick_value());
				sent++;
				burst--;
			end
			gap = (sender_idles != 0) ? $urandom_range(0, 6) : 0;
			if (gap > 0) begin
				@(negedge clk) src_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		@(negedge clk) src_valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task pick_config(input int phase);
		logic [MIN_W-1:0] mind;
		case (phase)
			0: begin
				set_reg(REG_RADIX, 7'h72);
				set_reg(REG_MIN_DIGITS, 7'd63);
				set_reg(REG_CHAR_BUDGET, 7'd64);
			end
			1: begin
				set_reg(REG_RADIX, 7'h0F);
				set_reg(REG_MIN_DIGITS, 7'h40);
				set_reg(REG_CHAR_BUDGET, 7'h7F);
			end
			default: begin
				set_reg(REG_RADIX, 7'($urandom_range(0, 127)));
				case ($urandom_range(0, 2))
					0: mind = '0;
					1: mind = MIN_W'($urandom_range(0, 20));
					default: mind = MIN_W'($urandom_range(0, 63));
				endcase
				set_reg(REG_MIN_DIGITS, {1'($urandom_range(0, 1)), mind});
				if ($urandom_range(0, 3) == 0)
					set_reg(REG_CHAR_BUDGET, 7'($urandom_range(0, 127)));
				else
					set_reg(REG_CHAR_BUDGET, 7'($urandom_range(CHAR_CAP - 8, 127)));
				if ($urandom_range(0, 3) == 0)
					set_reg(REG_UNUSED, 7'($urandom_range(0, 127)));
			end
		endcase
	endtask

	initial begin
		int phase;
		sb           = new();
		arst_n       = 1'b0;
		src_valid    = 1'b0;
		value        = '0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		rx_mode      = 1;
		sender_idles = 1;
		squeeze      = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// reset settings: decimal, no padding, full budget
		directed_q = '{64'd0, 64'd1, 64'd9, 64'd10, ALL_ONES};
		send_values(5);

		// radix below range holds at binary; 64 binary digits overflow the budget
		set_reg(REG_RADIX, 7'h00);
		directed_q = '{ALL_ONES, ~TOP_BIT, TOP_BIT};
		send_values(3);

		// budget above the cap
		set_reg(REG_RADIX, 7'h01);
		set_reg(REG_CHAR_BUDGET, 7'h41);
		directed_q = '{ALL_ONES};
		send_values(1);

		// radix above range holds at decimal; widest padding fills the budget
		set_reg(REG_RADIX, 7'h0B);
		set_reg(REG_MIN_DIGITS, 7'd63);
		set_reg(REG_CHAR_BUDGET, 7'd64);
		directed_q = '{64'd5, ALL_ONES};
		send_values(2);

		// minimum equal to budget
		set_reg(REG_MIN_DIGITS, 7'd10);
		set_reg(REG_CHAR_BUDGET, 7'd10);
		directed_q = '{64'd3};
		send_values(1);

		// zero budget
		set_reg(REG_MIN_DIGITS, 7'd0);
		set_reg(REG_CHAR_BUDGET, 7'd0);
		directed_q = '{64'd0};
		send_values(1);

		// no room for the terminator
		set_reg(REG_CHAR_BUDGET, 7'd1);
		directed_q = '{64'd0};
		send_values(1);

		set_reg(REG_RADIX, 7'h0F);
		set_reg(REG_CHAR_BUDGET, 7'd2);
		directed_q = '{64'd0, 64'd9, 64'd10};
		send_values(3);

		// unknown index must leave the registers alone
		set_reg(REG_UNUSED, 7'h7F);
		set_reg(REG_RADIX, 7'h35);
		set_reg(REG_CHAR_BUDGET, 7'd64);
		directed_q = '{64'd4, 64'd5, ALL_ONES};
		send_values(3);

		for (phase = 0; phase < PHASES; phase++) begin
			pick_config(phase);
			rx_mode      = phase % 5;
			sender_idles = ((phase % 3) != 0) ? 1 : 0;
			if (phase == 3 || phase == 7) begin
				sender_idles = 0;
				rx_mode      = 0;
				squeeze      = 1'b1;
			end
			send_values(PHASE_ITEMS);
		end

		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

### filelist.f
sv/udc_pkg.sv
sv/udc_div_step.sv
sv/udc_digit_ram.sv
sv/unsigned_to_digit_string.sv
sv/udc_checker.sv
bench/tb_unsigned_to_digit_string.sv
